// ===== hw/rtl/tcis_pkg.sv =====
// ============================================================================
// TTL CPU instruction step package
// Shared constants, instruction field codes, state and request types, and
// the address forming helpers used by the core, the memory port and the
// execute unit.
// ============================================================================
package tcis_pkg;

  // Address widths of the data RAM and the program space.
  localparam int RAM_ADDR_BITS = 17;
  localparam int ROM_ADDR_BITS = 16;
  localparam int RAM_DEPTH     = 1 << RAM_ADDR_BITS;

  // With more than 64K of RAM, a store on the RAM bus writes the expansion
  // control register instead of memory.
  localparam bit CTRL_VIA_STORE = (RAM_ADDR_BITS > 16);

  // Operation codes, instruction bits [15:13].
  localparam logic [2:0] OP_LD  = 3'd0;
  localparam logic [2:0] OP_AND = 3'd1;
  localparam logic [2:0] OP_OR  = 3'd2;
  localparam logic [2:0] OP_XOR = 3'd3;
  localparam logic [2:0] OP_ADD = 3'd4;
  localparam logic [2:0] OP_SUB = 3'd5;
  localparam logic [2:0] OP_ST  = 3'd6;
  localparam logic [2:0] OP_BR  = 3'd7;

  // Addressing and destination modes, instruction bits [12:10].
  localparam logic [2:0] MODE_D_AC   = 3'd0;
  localparam logic [2:0] MODE_X_AC   = 3'd1;
  localparam logic [2:0] MODE_YD_AC  = 3'd2;
  localparam logic [2:0] MODE_YX_AC  = 3'd3;
  localparam logic [2:0] MODE_TO_X   = 3'd4;
  localparam logic [2:0] MODE_TO_Y   = 3'd5;
  localparam logic [2:0] MODE_TO_OUT = 3'd6;
  localparam logic [2:0] MODE_YXINC  = 3'd7;

  // Branch conditions, same bits as the mode field.
  localparam logic [2:0] BR_FAR    = 3'd0;
  localparam logic [2:0] BR_GT     = 3'd1;
  localparam logic [2:0] BR_LT     = 3'd2;
  localparam logic [2:0] BR_NE     = 3'd3;
  localparam logic [2:0] BR_EQ     = 3'd4;
  localparam logic [2:0] BR_GE     = 3'd5;
  localparam logic [2:0] BR_LE     = 3'd6;
  localparam logic [2:0] BR_ALWAYS = 3'd7;

  // Bus sources, instruction bits [9:8].
  localparam logic [1:0] BUS_D   = 2'd0;
  localparam logic [1:0] BUS_RAM = 2'd1;
  localparam logic [1:0] BUS_AC  = 2'd2;
  localparam logic [1:0] BUS_IN  = 2'd3;

  localparam logic [15:0] CTRL_MASK  = 16'h80FD;
  localparam logic [15:0] CTRL_RESET = 16'h007C;
  localparam logic [16:0] BANK_FLIP  = 17'h08000;
  localparam logic [7:0]  OUTX_MASK  = 8'h40;
  localparam logic [7:0]  SIGN_FLIP  = 8'h80;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] mode;
    logic [1:0] bus;
    logic [7:0] d;
    logic [7:0] inb;
    logic [7:0] miso;
  } item_t;

  typedef struct packed {
    logic [ROM_ADDR_BITS-1:0] pc;
    logic [ROM_ADDR_BITS-1:0] npc;
    logic [7:0]               ac;
    logic [7:0]               x;
    logic [7:0]               y;
    logic [7:0]               out;
    logic [7:0]               outx;
    logic [15:0]              ctrl;
    logic [16:0]              bank;
  } state_t;

  localparam state_t STATE_RESET = '{
    pc:   '0,
    npc:  ROM_ADDR_BITS'(1),
    ac:   8'h00,
    x:    8'h00,
    y:    8'h00,
    out:  8'h00,
    outx: 8'h00,
    ctrl: CTRL_RESET,
    bank: 17'h00000
  };

  typedef struct packed {
    logic                     we;
    logic                     re;
    logic [RAM_ADDR_BITS-1:0] addr;
    logic [7:0]               wdata;
  } ram_req_t;

  typedef struct packed {
    logic [15:0] fetch_addr;
    logic [7:0]  out_port;
    logic [7:0]  outx_port;
    logic [15:0] ctrl_value;
  } result_t;

  // Logical 16-bit RAM address formed by the mode field.
  function automatic logic [15:0] ram_offset(input logic [2:0] mode, input logic [7:0] d,
                                             input logic [7:0] x, input logic [7:0] y);
    logic [15:0] a;
    case (mode) inside
      MODE_X_AC:              a = {8'h00, x};
      MODE_YD_AC:             a = {y, d};
      MODE_YX_AC, MODE_YXINC: a = {y, x};
      default:                a = {8'h00, d};
    endcase
    return a;
  endfunction

  // Upper half of the address space is remapped through the bank value.
  function automatic logic [RAM_ADDR_BITS-1:0] bank_map(input logic [15:0] a,
                                                        input logic [16:0] bank);
    logic [16:0] p;
    p = {1'b0, a};
    if (a[15]) begin
      p = p ^ bank;
    end
    return p[RAM_ADDR_BITS-1:0];
  endfunction

  function automatic logic [RAM_ADDR_BITS-1:0] zero_page_addr(input logic [7:0] d);
    logic [RAM_ADDR_BITS-1:0] a;
    a      = '0;
    a[7:0] = d;
    return a;
  endfunction

  function automatic logic [15:0] pc_to_word(input logic [ROM_ADDR_BITS-1:0] pc);
    logic [15:0] w;
    w                    = '0;
    w[ROM_ADDR_BITS-1:0] = pc;
    return w;
  endfunction

endpackage

// ===== hw/rtl/tcis_ram.sv =====
// ============================================================================
// Generic single-port RAM
// One address for a write or a read per cycle; the read data is registered
// and holds until the next read.
// ============================================================================
module tcis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tcis_mem_port.sv =====
// ============================================================================
// TTL CPU memory port
// Forms the RAM request of an incoming instruction from the up-to-date
// register state: store writes, ALU operand reads and branch operand reads.
// ============================================================================
module tcis_mem_port (
  input  logic                tcis_accept_i,
  input  tcis_pkg::item_t     item_i,
  input  tcis_pkg::state_t    st_i,
  output tcis_pkg::ram_req_t  req_o
);

  logic [15:0]                        log_addr;
  logic [tcis_pkg::RAM_ADDR_BITS-1:0] bank_addr;

  assign log_addr  = tcis_pkg::ram_offset(item_i.mode, item_i.d, st_i.x, st_i.y);
  assign bank_addr = tcis_pkg::bank_map(log_addr, st_i.bank);

  always_comb begin
    req_o = '0;
    unique case (item_i.op) inside
      tcis_pkg::OP_ST: begin
        req_o.addr = bank_addr;
        req_o.we   = tcis_accept_i &&
                     ((item_i.bus != tcis_pkg::BUS_RAM) || !tcis_pkg::CTRL_VIA_STORE);
        case (item_i.bus)
          tcis_pkg::BUS_D:  req_o.wdata = item_i.d;
          tcis_pkg::BUS_AC: req_o.wdata = st_i.ac;
          tcis_pkg::BUS_IN: req_o.wdata = item_i.inb;
          default:          req_o.wdata = 8'h00;
        endcase
      end
      tcis_pkg::OP_BR: begin
        // Branch operands come straight from the zero page, no banking.
        req_o.addr = tcis_pkg::zero_page_addr(item_i.d);
        req_o.re   = tcis_accept_i && (item_i.bus == tcis_pkg::BUS_RAM);
      end
      default: begin
        // With CTRL bit 0 set the RAM bus carries the SPI byte instead.
        req_o.addr = bank_addr;
        req_o.re   = tcis_accept_i && (item_i.bus == tcis_pkg::BUS_RAM) && !st_i.ctrl[0];
      end
    endcase
  end

endmodule

// ===== hw/rtl/tcis_exec.sv =====
// ============================================================================
// TTL CPU execute unit
// Applies one instruction to the register state: ALU ops, stores with the
// control register write, branches, the OUTX latch and the X increment.
// ============================================================================
module tcis_exec (
  input  tcis_pkg::item_t   item_i,
  input  tcis_pkg::state_t  st_i,
  input  logic [7:0]        rdata_i,
  output tcis_pkg::state_t  st_o,
  output tcis_pkg::result_t res_o
);

  logic [7:0]  bus_val;
  logic [7:0]  alu_res;
  logic [7:0]  cmp_val;
  logic [15:0] log_addr;
  logic [15:0] new_pc_word;
  logic [15:0] br_base;
  logic [15:0] br_full;
  logic        take;

  assign log_addr    = tcis_pkg::ram_offset(item_i.mode, item_i.d, st_i.x, st_i.y);
  assign new_pc_word = tcis_pkg::pc_to_word(st_i.npc);
  assign cmp_val     = st_i.ac ^ tcis_pkg::SIGN_FLIP;

  // Operand bus; on ALU ops the RAM source turns into the SPI byte when enabled.
  always_comb begin
    case (item_i.bus)
      tcis_pkg::BUS_D:   bus_val = item_i.d;
      tcis_pkg::BUS_RAM: begin
        if (item_i.op != tcis_pkg::OP_BR && st_i.ctrl[0]) begin
          bus_val = item_i.miso;
        end else begin
          bus_val = rdata_i;
        end
      end
      tcis_pkg::BUS_AC:  bus_val = st_i.ac;
      default:           bus_val = item_i.inb;
    endcase
  end

  always_comb begin
    case (item_i.op)
      tcis_pkg::OP_AND: alu_res = st_i.ac & bus_val;
      tcis_pkg::OP_OR:  alu_res = st_i.ac | bus_val;
      tcis_pkg::OP_XOR: alu_res = st_i.ac ^ bus_val;
      tcis_pkg::OP_ADD: alu_res = st_i.ac + bus_val;
      tcis_pkg::OP_SUB: alu_res = st_i.ac - bus_val;
      default:          alu_res = bus_val;
    endcase
  end

  // Branch condition on the accumulator seen as a signed byte.
  always_comb begin
    br_base = {new_pc_word[15:8], 8'h00};
    unique case (item_i.mode)
      tcis_pkg::BR_FAR: begin
        take    = 1'b1;
        br_base = {st_i.y, 8'h00};
      end
      tcis_pkg::BR_GT: take = cmp_val > tcis_pkg::SIGN_FLIP;
      tcis_pkg::BR_LT: take = cmp_val < tcis_pkg::SIGN_FLIP;
      tcis_pkg::BR_NE: take = cmp_val != tcis_pkg::SIGN_FLIP;
      tcis_pkg::BR_EQ: take = cmp_val == tcis_pkg::SIGN_FLIP;
      tcis_pkg::BR_GE: take = cmp_val >= tcis_pkg::SIGN_FLIP;
      tcis_pkg::BR_LE: take = cmp_val <= tcis_pkg::SIGN_FLIP;
      default:         take = 1'b1;
    endcase
  end

  assign br_full = br_base | {8'h00, bus_val};

  always_comb begin
    st_o     = st_i;
    st_o.pc  = st_i.npc;
    st_o.npc = st_i.npc + {{(tcis_pkg::ROM_ADDR_BITS-1){1'b0}}, 1'b1};
    unique case (item_i.op) inside
      tcis_pkg::OP_ST: begin
        if (item_i.bus == tcis_pkg::BUS_RAM && tcis_pkg::CTRL_VIA_STORE) begin
          st_o.ctrl = log_addr & tcis_pkg::CTRL_MASK;
          st_o.bank = {st_o.ctrl[7], st_o.ctrl[6], 15'd0} ^ tcis_pkg::BANK_FLIP;
        end
        if (item_i.mode == tcis_pkg::MODE_TO_X) begin
          st_o.x = st_i.ac;
        end else if (item_i.mode == tcis_pkg::MODE_TO_Y) begin
          st_o.y = st_i.ac;
        end
      end
      tcis_pkg::OP_BR: begin
        if (take) begin
          st_o.npc = br_full[tcis_pkg::ROM_ADDR_BITS-1:0];
        end
      end
      default: begin
        case (item_i.mode) inside
          tcis_pkg::MODE_TO_X: st_o.x = alu_res;
          tcis_pkg::MODE_TO_Y: st_o.y = alu_res;
          tcis_pkg::MODE_TO_OUT, tcis_pkg::MODE_YXINC: begin
            // A rising edge on OUT bit 6 latches the accumulator into OUTX.
            if ((~st_i.out & alu_res & tcis_pkg::OUTX_MASK) != 8'h00) begin
              st_o.outx = st_i.ac;
            end
            st_o.out = alu_res;
          end
          default: st_o.ac = alu_res;
        endcase
      end
    endcase
    if (item_i.mode == tcis_pkg::MODE_YXINC && item_i.op != tcis_pkg::OP_BR) begin
      st_o.x = st_o.x + 8'd1;
    end
  end

  assign res_o.fetch_addr = tcis_pkg::pc_to_word(st_o.pc);
  assign res_o.out_port   = st_o.out;
  assign res_o.outx_port  = st_o.outx;
  assign res_o.ctrl_value = st_o.ctrl;

endmodule

// ===== hw/rtl/ttl_cpu_instruction_step_core.sv =====
// ============================================================================
// TTL CPU instruction step core
// Executes one instruction of an 8-bit TTL computer with a 128K RAM
// expansion per item and reports the next fetch address and the outputs.
// ============================================================================
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | to core   | in_valid_i / in_stall_o | instr_word_i, in_value_i,
//           |           |                         | miso_value_i
//   out     | from core | out_valid_o/out_stall_i | fetch_addr_o, out_port_o,
//           |           |                         | outx_port_o, ctrl_value_o
//
// One item per cycle sustained while the out channel does not stall; an
// accepted item passes the execute stage and then the result register,
// from which it shows on the out channel.
// The RAM access of an item (store write or operand read) is issued at the
// edge that accepts it, using the register state forwarded from the item
// that executes in that same cycle, so the single RAM port is used at most
// once per cycle and always in program order.
// Reset is asynchronous; it loads the architectural registers with their
// power-up values (next fetch at address 1, CTRL 0x7C) and empties both
// stages. Data RAM contents are not cleared.
// A stall on the out channel holds the result register; the execute stage
// then holds too and in_stall_o rises only while both stages are full.

module ttl_cpu_instruction_step_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] instr_word_i,
  input  logic [7:0]  in_value_i,
  input  logic [7:0]  miso_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] fetch_addr_o,
  output logic [7:0]  out_port_o,
  output logic [7:0]  outx_port_o,
  output logic [15:0] ctrl_value_o
);

  // Execute stage: the accepted item waits here for its RAM read data.
  logic                ex_v_q;
  tcis_pkg::item_t     ex_q;
  tcis_pkg::item_t     in_item;

  // Architectural state before the item held in the execute stage.
  tcis_pkg::state_t    st_q;
  tcis_pkg::state_t    st_exec;
  tcis_pkg::state_t    st_fwd;

  tcis_pkg::result_t   res_exec;
  tcis_pkg::result_t   res_q;
  logic                out_v_q;

  tcis_pkg::ram_req_t  ram_req;
  logic [7:0]          ram_rdata;

  logic                ex_adv;
  logic                accept;

  // The execute stage moves on when the result register is free or drains now.
  assign ex_adv     = ex_v_q && (!out_v_q || !out_stall_i);
  assign in_stall_o = ex_v_q && !ex_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_item.op   = instr_word_i[15:13];
  assign in_item.mode = instr_word_i[12:10];
  assign in_item.bus  = instr_word_i[9:8];
  assign in_item.d    = instr_word_i[7:0];
  assign in_item.inb  = in_value_i;
  assign in_item.miso = miso_value_i;

  // A new item sees the state as left by the item that executes this cycle.
  assign st_fwd = ex_v_q ? st_exec : st_q;

  tcis_mem_port u_mem_port (
    .tcis_accept_i (accept),
    .item_i        (in_item),
    .st_i          (st_fwd),
    .req_o         (ram_req)
  );

  tcis_ram #(
    .WIDTH (8),
    .DEPTH (tcis_pkg::RAM_DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .re_i    (ram_req.re),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  tcis_exec u_exec (
    .item_i  (ex_q),
    .st_i    (st_q),
    .rdata_i (ram_rdata),
    .st_o    (st_exec),
    .res_o   (res_exec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      st_q    <= tcis_pkg::STATE_RESET;
    end else begin
      if (accept) begin
        ex_v_q <= 1'b1;
      end else if (ex_adv) begin
        ex_v_q <= 1'b0;
      end
      if (ex_adv) begin
        out_v_q <= 1'b1;
        st_q    <= st_exec;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ex_q <= in_item;
    end
    if (ex_adv) begin
      res_q <= res_exec;
    end
  end

  assign out_valid_o  = out_v_q;
  assign fetch_addr_o = res_q.fetch_addr;
  assign out_port_o   = res_q.out_port;
  assign outx_port_o  = res_q.outx_port;
  assign ctrl_value_o = res_q.ctrl_value;

  // The single RAM port never reads and writes in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.we && ram_req.re))
    else $error("RAM read and write issued together");

  // RAM traffic only comes from an item being accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req.we || ram_req.re) |-> accept)
    else $error("RAM access without an accepted item");

  // The control register only ever holds bits of its write mask.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.ctrl & ~tcis_pkg::CTRL_MASK) == 16'h0000)
    else $error("CTRL holds bits outside its mask");

  // Architectural state only changes when an item leaves the execute stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ex_adv |=> $stable(st_q))
    else $error("state changed with no item executing");

  // An executed item always lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_adv |=> out_v_q)
    else $error("executed item did not reach the output");

endmodule
